// ----- sv/sorted_release_time_queue_defines.svh -----
// ----------------------------------------------------------------------------
// sorted_release_time_queue_defines
// Assertion macros shared by the release time queue RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_RELEASE_TIME_QUEUE_DEFINES_SVH
`define SORTED_RELEASE_TIME_QUEUE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SRTQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("srtq assertion failed");

// Next-cycle implication, checked out of reset
`define SRTQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("srtq assertion failed");

`endif

// ----- sv/srtq_pkg.sv -----
// ----------------------------------------------------------------------------
// srtq_pkg
// Types and constants for the sorted release time queue.
// ----------------------------------------------------------------------------
`default_nettype none

package srtq_pkg;

    // Built depth default
    localparam int DEPTH_DEFAULT = 16;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int OP_W    = 2;
    localparam int CAP_W   = 5;
    localparam int COUNT_W = 5;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // Request opcodes (code three acts as a query)
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_POP     = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

    // Register word index
    localparam logic [0:0] REG_CAPACITY = 1'b0;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Shift controls broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- sv/srtq_cell.sv -----
// ----------------------------------------------------------------------------
// srtq_cell
// One slot of the sorted chain: compares the new time against its own entry
// and either holds, takes the new time, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module srtq_cell (
    input  wire logic                        i_clk,
    input  wire srtq_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [srtq_pkg::TIME_W-1:0] i_time,
    input  wire logic                        i_valid,
    input  wire logic                        i_left_valid,
    input  wire logic                        i_left_gt,
    input  wire logic [srtq_pkg::TIME_W-1:0] i_left_value,
    input  wire logic [srtq_pkg::TIME_W-1:0] i_right_value,
    output logic      [srtq_pkg::TIME_W-1:0] o_value,
    output logic      [srtq_pkg::TIME_W-1:0] o_next_value,
    output logic                             o_gt
);
    import srtq_pkg::*;

    logic [TIME_W-1:0] r_value;
    logic [TIME_W-1:0] n_value;
    logic              w_gt;

    // Occupied and later than the new time: this entry moves right
    assign w_gt = i_valid && (r_value > i_time);

    // Next entry
    always_comb begin
        n_value = r_value;
        if (i_ctrl.pop) begin
            n_value = i_right_value;
        end else if (i_ctrl.ins) begin
            if (i_left_gt) begin
                n_value = i_left_value;
            end else if ((w_gt || !i_valid) && i_left_valid) begin
                // first slot that is free or later: insertion point
                n_value = i_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value      = r_value;
    assign o_next_value = n_value;
    assign o_gt         = w_gt;

endmodule

`default_nettype wire

// ----- sv/sorted_release_time_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_release_time_queue
// Bounded priority queue of release times, ascending, earliest at the head.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle and its result is held in the output
// register, so a steady stream runs at one item per cycle while the output
// side takes each result. The rate is set by the chain of DEPTH cells:
// every cell compares the new time with its own entry in the same cycle, and
// an insert or pop shifts the whole chain by one slot at once. A new
// request is taken while the previous result still waits, as long as the
// output side takes that result in the same cycle. Equal times queue behind
// those already present. The capacity register, clamped to between one and
// DEPTH, bounds the count; lowering it below the count keeps the entries and
// refuses enqueues until pops bring the count down.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_release_time_queue #(
    parameter int DEPTH = srtq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // request channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [srtq_pkg::OP_W-1:0]    i_opcode,
    input  wire logic [srtq_pkg::TIME_W-1:0]  i_release_time,
    // result channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [srtq_pkg::TIME_W-1:0]  o_head_time,
    output logic      [srtq_pkg::TIME_W-1:0]  o_popped_time,
    output logic      [srtq_pkg::COUNT_W-1:0] o_entry_count,
    output logic                              o_is_empty,
    output logic                              o_is_full,
    output logic                              o_op_error,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [srtq_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [srtq_pkg::DATA_W-1:0]  pwdata,
    output logic      [srtq_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import srtq_pkg::*;

`include "sorted_release_time_queue_defines.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Configuration
    logic [CAP_W-1:0] r_capacity;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (w_cfg_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY) ?
                    {{(DATA_W-CAP_W){1'b0}}, r_capacity} : '0;

    // Capacity clamped to 1..DEPTH
    logic [CMP_W-1:0] w_cap_ext;
    logic [CMP_W-1:0] w_eff_cap;

    assign w_cap_ext = CMP_W'(r_capacity);

    always_comb begin
        w_eff_cap = w_cap_ext;
        if (w_cap_ext == '0) begin
            w_eff_cap = CMP_W'(1);
        end else if (w_cap_ext > CMP_W'(DEPTH)) begin
            w_eff_cap = CMP_W'(DEPTH);
        end
    end

    // Handshake and request decode
    logic             r_out_valid;
    logic             w_accept;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_full_now;
    logic             w_empty_now;
    logic             w_err;
    t_cell_ctrl       w_ctrl;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_full_now  = CMP_W'(r_count) >= w_eff_cap;
    assign w_empty_now = (r_count == '0);

    always_comb begin
        w_ctrl.ins = 1'b0;
        w_ctrl.pop = 1'b0;
        w_err      = 1'b0;
        case (i_opcode)
            OP_ENQUEUE: begin
                w_ctrl.ins = w_accept && !w_full_now;
                w_err      = w_full_now;
            end
            OP_POP: begin
                w_ctrl.pop = w_accept && !w_empty_now;
                w_err      = w_empty_now;
            end
            default: begin
                // query, and the unused code acting as a query
            end
        endcase
    end

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (w_ctrl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Cell chain
    logic [TIME_W-1:0] w_value [DEPTH];
    logic [TIME_W-1:0] w_next  [DEPTH];
    logic              w_gt    [DEPTH];
    logic              w_valid [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [TIME_W-1:0] w_left_value;
        logic [TIME_W-1:0] w_right_value;
        logic              w_left_valid;
        logic              w_left_gt;

        assign w_valid[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_left_value = '0;
            assign w_left_valid = 1'b1;
            assign w_left_gt    = 1'b0;
        end else begin : g_body
            assign w_left_value = w_value[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_gt    = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
        end else begin : g_mid
            assign w_right_value = w_value[g+1];
        end

        srtq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_time        (i_release_time),
            .i_valid       (w_valid[g]),
            .i_left_valid  (w_left_valid),
            .i_left_gt     (w_left_gt),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_value       (w_value[g]),
            .o_next_value  (w_next[g]),
            .o_gt          (w_gt[g])
        );
    end

    // Result register
    logic [TIME_W-1:0]  r_head_time;
    logic [TIME_W-1:0]  r_popped_time;
    logic [COUNT_W-1:0] r_entry_count;
    logic               r_is_empty;
    logic               r_is_full;
    logic               r_op_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_head_time   <= (n_count != '0) ? w_next[0] : '0;
            r_popped_time <= w_ctrl.pop ? w_value[0] : '0;
            r_entry_count <= COUNT_W'(n_count);
            r_is_empty    <= (n_count == '0);
            r_is_full     <= CMP_W'(n_count) >= w_eff_cap;
            r_op_error    <= w_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_head_time   = r_head_time;
    assign o_popped_time = r_popped_time;
    assign o_entry_count = r_entry_count;
    assign o_is_empty    = r_is_empty;
    assign o_is_full     = r_is_full;
    assign o_op_error    = r_op_error;

    // Checks
    `SRTQ_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(DEPTH))
    `SRTQ_ASSERT_NOW(a_single_shift, 1'b1, !(w_ctrl.ins && w_ctrl.pop))
    `SRTQ_ASSERT_NEXT(a_pop_dec, w_ctrl.pop, r_count == $past(r_count) - CNT_W'(1))
    `SRTQ_ASSERT_NEXT(a_err_keeps, w_accept && w_err, r_count == $past(r_count))
    `SRTQ_ASSERT_NEXT(a_result_after_req, w_accept, r_out_valid)

endmodule

`default_nettype wire
